FILE: hdl/sdr_pkg.sv
`timescale 1ns / 1ps
// types and constants shared by the smoothstep duty ramp modules
// no dependencies

package sdr_pkg;

  localparam int DIV_W  = 35;
  localparam int QUO_W  = 16;
  localparam int STEP_W = 5;

  localparam logic [STEP_W-1:0] HOLD_STEPS  = 5'd16;
  localparam logic [STEP_W-1:0] CURVE_STEPS = 5'd10;
  localparam logic signed [11:0] CURVE_BIAS = 12'sd256;

  localparam logic REQ_START = 1'b0;
  localparam logic REQ_TICK  = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [7:0]  init_duty;
    logic [7:0]  final_duty;
    logic [15:0] span_ms;
    logic [7:0]  step_count;
  } sdr_req_t;

  typedef struct packed {
    logic [7:0] duty;
    logic       ramp_done;
  } sdr_res_t;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;
    logic [DIV_W-1:0]  divisor;
    logic [STEP_W-1:0] steps;
  } sdr_div_cmd_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quotient;
  } sdr_div_rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_HOLD_DIV,
    S_M1,
    S_M2,
    S_M3,
    S_M4,
    S_M5,
    S_PREP,
    S_CURVE_DIV,
    S_EMIT
  } sdr_state_t;

endpackage

FILE: hdl/sdr_div.sv
`timescale 1ns / 1ps
// shared restoring divider, one quotient bit per cycle
// depends on sdr_pkg

module sdr_div (
  input  logic                  clk,
  input  logic                  rst,
  input  sdr_pkg::sdr_div_cmd_t cmd,
  output sdr_pkg::sdr_div_rsp_t rsp
);
  import sdr_pkg::*;

  logic [DIV_W-1:0]  rem;
  logic [DIV_W-1:0]  dsh;
  logic [QUO_W-1:0]  quo;
  logic [STEP_W-1:0] cnt;
  logic              busy;
  logic              done;
  logic              fits;

  assign fits = (rem >= dsh);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
        cnt  <= cmd.steps;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      rem <= cmd.dividend;
      dsh <= cmd.divisor;
      quo <= '0;
    end else if (busy) begin
      if (fits) begin
        rem <= rem - dsh;
      end
      quo <= {quo[QUO_W-2:0], fits};
      dsh <= dsh >> 1;
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

FILE: hdl/smoothstep_duty_ramp_core.sv
`timescale 1ns / 1ps
// smoothstep s-curve pwm duty ramp, top level with sequencer and output register
// depends on sdr_pkg and sdr_div
//
// A request is either a ramp start or a one millisecond tick. A start answers with the
// start duty (or with the target duty and ramp_done when steps or duration is zero); each
// tick that completes a hold answers with the next curve point, and the tick after the
// last point's hold answers with ramp_done. Quiet ticks and zero-length starts are handled
// in the idle state. A normal start runs 16 passes of the shared divider to find the hold
// length. A tick that yields a curve point makes five passes through one 24x10 multiplier,
// then 10 passes of the shared divider. The block takes no request while it works or while
// a result waits on a stalled output.

module smoothstep_duty_ramp_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  sdr_pkg::sdr_req_t in_req,
  output logic              out_valid,
  input  logic              out_stall,
  output sdr_pkg::sdr_res_t out_res
);
  import sdr_pkg::*;

  sdr_state_t state, state_next;

  logic              active, active_next;
  logic [7:0]        base_level, base_level_next;
  logic signed [8:0] level_change, level_change_next;
  logic [7:0]        total_intervals, total_intervals_next;
  logic [7:0]        interval_index, interval_index_next;
  logic [15:0]       hold_length, hold_length_next;
  logic [15:0]       tick_count, tick_count_next;
  logic [7:0]        current_duty, current_duty_next;
  logic [23:0]       prod, prod_next;
  logic [31:0]       num, num_next;
  logic [23:0]       den, den_next;
  logic [7:0]        res_duty, res_duty_next;
  logic              res_done, res_done_next;

  logic [23:0]       mul_a;
  logic [9:0]        mul_b;
  logic [33:0]       mul_p;
  logic [15:0]       tick_inc;
  logic [9:0]        weight;
  logic [8:0]        change_mag;
  logic [DIV_W-1:0]  den513;
  logic [DIV_W-1:0]  num2;
  logic signed [11:0] curve_sum;
  logic [7:0]        curve_duty;

  logic              out_write;
  sdr_res_t          out_wdata;
  logic              accept;

  sdr_div_cmd_t      div_cmd;
  sdr_div_rsp_t      div_rsp;

  sdr_div u_div (
    .clk (clk),
    .rst (rst),
    .cmd (div_cmd),
    .rsp (div_rsp)
  );

  assign in_stall = (state != S_IDLE) || (out_valid && out_stall);
  assign accept   = in_valid && !in_stall;

  assign mul_p      = mul_a * mul_b;
  assign tick_inc   = tick_count + 16'd1;
  assign weight     = {1'b0, total_intervals, 1'b0} + {2'b00, total_intervals}
                    - {1'b0, interval_index, 1'b0};
  assign change_mag = level_change[8] ? 9'(-level_change) : 9'(level_change);
  assign den513     = {2'b00, den, 9'b0} + {11'b0, den};
  assign num2       = {2'b00, num, 1'b0};
  assign curve_sum  = $signed({4'b0000, base_level})
                    + $signed({2'b00, div_rsp.quotient[9:0]}) - CURVE_BIAS;

  always_comb begin
    if (curve_sum < 12'sd0) begin
      curve_duty = 8'd0;
    end else if (curve_sum > 12'sd255) begin
      curve_duty = 8'd255;
    end else begin
      curve_duty = curve_sum[7:0];
    end
  end

  always_comb begin
    state_next           = state;
    active_next          = active;
    base_level_next      = base_level;
    level_change_next    = level_change;
    total_intervals_next = total_intervals;
    interval_index_next  = interval_index;
    hold_length_next     = hold_length;
    tick_count_next      = tick_count;
    current_duty_next    = current_duty;
    prod_next            = prod;
    num_next             = num;
    den_next             = den;
    res_duty_next        = res_duty;
    res_done_next        = res_done;
    mul_a                = '0;
    mul_b                = '0;
    div_cmd              = '0;
    out_write            = 1'b0;
    out_wdata            = '{duty: res_duty, ramp_done: res_done};

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (in_req.req_type == REQ_START) begin
            if (in_req.step_count == 8'd0 || in_req.span_ms == 16'd0) begin
              active_next       = 1'b0;
              current_duty_next = in_req.final_duty;
              out_write         = 1'b1;
              out_wdata         = '{duty: in_req.final_duty, ramp_done: 1'b1};
            end else begin
              base_level_next      = in_req.init_duty;
              level_change_next    = $signed({1'b0, in_req.final_duty})
                                   - $signed({1'b0, in_req.init_duty});
              total_intervals_next = in_req.step_count;
              interval_index_next  = 8'd0;
              tick_count_next      = 16'd0;
              current_duty_next    = in_req.init_duty;
              active_next          = 1'b1;
              res_duty_next        = in_req.init_duty;
              res_done_next        = 1'b0;
              div_cmd.start        = 1'b1;
              div_cmd.dividend     = {19'b0, in_req.span_ms};
              div_cmd.divisor      = {12'b0, in_req.step_count, 15'b0};
              div_cmd.steps        = HOLD_STEPS;
              state_next           = S_HOLD_DIV;
            end
          end else if (active) begin
            if (tick_inc < hold_length) begin
              tick_count_next = tick_inc;
            end else begin
              tick_count_next = 16'd0;
              if (interval_index >= total_intervals) begin
                active_next = 1'b0;
                out_write   = 1'b1;
                out_wdata   = '{duty: current_duty, ramp_done: 1'b1};
              end else begin
                interval_index_next = interval_index + 8'd1;
                state_next          = S_M1;
              end
            end
          end
        end
      end
      S_HOLD_DIV: begin
        if (div_rsp.done) begin
          hold_length_next = (div_rsp.quotient == 16'd0) ? 16'd1 : div_rsp.quotient;
          state_next       = S_EMIT;
        end
      end
      S_M1: begin
        mul_a      = {16'b0, interval_index};
        mul_b      = {2'b00, interval_index};
        prod_next  = mul_p[23:0];
        state_next = S_M2;
      end
      S_M2: begin
        mul_a      = prod;
        mul_b      = weight;
        prod_next  = mul_p[23:0];
        state_next = S_M3;
      end
      S_M3: begin
        mul_a      = prod;
        mul_b      = {1'b0, change_mag};
        num_next   = mul_p[31:0];
        state_next = S_M4;
      end
      S_M4: begin
        mul_a      = {16'b0, total_intervals};
        mul_b      = {2'b00, total_intervals};
        prod_next  = mul_p[23:0];
        state_next = S_M5;
      end
      S_M5: begin
        mul_a      = prod;
        mul_b      = {2'b00, total_intervals};
        den_next   = mul_p[23:0];
        state_next = S_PREP;
      end
      S_PREP: begin
        div_cmd.start    = 1'b1;
        div_cmd.dividend = level_change[8] ? (den513 - num2) : (den513 + num2);
        div_cmd.divisor  = {1'b0, den, 10'b0};
        div_cmd.steps    = CURVE_STEPS;
        state_next       = S_CURVE_DIV;
      end
      S_CURVE_DIV: begin
        if (div_rsp.done) begin
          current_duty_next = curve_duty;
          res_duty_next     = curve_duty;
          res_done_next     = 1'b0;
          state_next        = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!(out_valid && out_stall)) begin
          out_write  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      active    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      active    <= active_next;
      out_valid <= out_write || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    base_level      <= base_level_next;
    level_change    <= level_change_next;
    total_intervals <= total_intervals_next;
    interval_index  <= interval_index_next;
    hold_length     <= hold_length_next;
    tick_count      <= tick_count_next;
    current_duty    <= current_duty_next;
    prod            <= prod_next;
    num             <= num_next;
    den             <= den_next;
    res_duty        <= res_duty_next;
    res_done        <= res_done_next;
    if (out_write) begin
      out_res <= out_wdata;
    end
  end

endmodule

FILE: hdl/sdr_checker.sv
`timescale 1ns / 1ps
// port-level checks for the smoothstep duty ramp, bound to the top level
// depends on sdr_pkg and smoothstep_duty_ramp_core

module sdr_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input sdr_pkg::sdr_req_t in_req,
  input logic              out_valid,
  input logic              out_stall,
  input sdr_pkg::sdr_res_t out_res
);
  import sdr_pkg::*;

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_res))
    else $error("stalled result changed");

  // no request taken while a result is stuck
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> in_stall)
    else $error("request taken with output blocked");

  // zero-length ramp finishes at once on the target
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && in_req.req_type == REQ_START
      && (in_req.step_count == 8'd0 || in_req.span_ms == 16'd0)
    |=> out_valid && out_res.ramp_done && out_res.duty == $past(in_req.final_duty))
    else $error("zero-length ramp result wrong");

  // reset empties the output
  assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind smoothstep_duty_ramp_core sdr_checker u_sdr_checker (.*);
